FILE: design/smef_pkg.sv
// Shared constants, register codes and beat types for the sonar median / EMA filter.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smef_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int WINDOW       = 5;
  localparam int MEDIAN_RANK  = 2;

  // rank beyond the window picks the largest sample
  localparam int RANK = (MEDIAN_RANK < WINDOW) ? MEDIAN_RANK : (WINDOW - 1);

  localparam int SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int TAG_W    = 10;
  localparam int READ_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int ALPHA_W  = 9;
  localparam int SMOOTH_W = 24;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [1:0] REG_NO_ECHO  = 2'd0;
  localparam logic [1:0] REG_ALPHA    = 2'd1;
  localparam logic [1:0] REG_TAG_BASE = 2'd2;

  localparam logic [SAMPLE_W-1:0] NO_ECHO_RESET  = 16'd200;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET    = 9'd205;
  localparam logic [TAG_W-1:0]    TAG_BASE_RESET = 10'd100;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE      = 9'd256;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [WINDOW-1:0] window_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] no_echo;
    logic [ALPHA_W-1:0]  alpha;
    logic [TAG_W-1:0]    tag_base;
  } cfg_t;

  typedef struct packed {
    logic [SEL_W-1:0] sensor;
    window_t          samples;
  } win_beat_t;

  typedef struct packed {
    logic [SEL_W-1:0] sensor;
    sample_t          median;
  } med_beat_t;

endpackage

`default_nettype wire

FILE: design/sonar_median_ema_filter_top.sv
// Sonar median / EMA filter: ring stage -> median stage -> average stage -> result.
// Registers in order: input register, ring output, median output, result register.
// Throughput: one reading per cycle while in_stall is low; the stages advance
// independently, so bubbles close up while a result waits on out_stall.
// Reset: synchronous rst clears all rings, ring positions, averages and valid flags
// and loads the register reset values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sonar_median_ema_filter_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic        [smef_pkg::ADDR_W-1:0] paddr,
  input  wire logic        [smef_pkg::DATA_W-1:0] pwdata,
  output logic             [smef_pkg::DATA_W-1:0] prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [smef_pkg::TAG_W-1:0]  sensor_tag,
  input  wire logic signed [smef_pkg::READ_W-1:0] reading,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [smef_pkg::IDX_W-1:0]  sensor_index,
  output logic             [smef_pkg::SAMPLE_W-1:0] window_median,
  output logic             [smef_pkg::SMOOTH_W-1:0] smoothed_q8
);

  smef_pkg::cfg_t      cfg;
  logic                win_valid;
  logic                win_ready;
  smef_pkg::win_beat_t win_beat;
  logic                med_valid;
  logic                med_ready;
  smef_pkg::med_beat_t med_beat;

  smef_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smef_ring_stage u_ring (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sensor_tag (sensor_tag),
    .reading    (reading),
    .out_valid  (win_valid),
    .out_beat   (win_beat),
    .out_ready  (win_ready)
  );

  smef_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_beat   (win_beat),
    .in_ready  (win_ready),
    .out_valid (med_valid),
    .out_beat  (med_beat),
    .out_ready (med_ready)
  );

  smef_ema_stage u_ema (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (med_valid),
    .in_beat       (med_beat),
    .in_ready      (med_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sensor_index  (sensor_index),
    .window_median (window_median),
    .smoothed_q8   (smoothed_q8)
  );

endmodule

`default_nettype wire

FILE: design/smef_cfg_regs.sv
// APB register file: no-echo distance, alpha and sonar tag base.
// Depends on smef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smef_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [smef_pkg::ADDR_W-1:0] paddr,
  input  wire logic [smef_pkg::DATA_W-1:0] pwdata,
  output logic      [smef_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output smef_pkg::cfg_t                  cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_echo  <= smef_pkg::NO_ECHO_RESET;
      cfg.alpha    <= smef_pkg::ALPHA_RESET;
      cfg.tag_base <= smef_pkg::TAG_BASE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        smef_pkg::REG_NO_ECHO:  cfg.no_echo  <= pwdata[smef_pkg::SAMPLE_W-1:0];
        smef_pkg::REG_ALPHA:    cfg.alpha    <= pwdata[smef_pkg::ALPHA_W-1:0];
        smef_pkg::REG_TAG_BASE: cfg.tag_base <= pwdata[smef_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      smef_pkg::REG_NO_ECHO:  prdata = smef_pkg::DATA_W'(cfg.no_echo);
      smef_pkg::REG_ALPHA:    prdata = smef_pkg::DATA_W'(cfg.alpha);
      smef_pkg::REG_TAG_BASE: prdata = smef_pkg::DATA_W'(cfg.tag_base);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/smef_ring_stage.sv
// Input register, tag decode, sample conditioning and per-sensor sample rings.
// Depends on smef_pkg; emits the updated window of the selected sensor.
`timescale 1ns / 1ps
`default_nettype none

module smef_ring_stage (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire smef_pkg::cfg_t                    cfg,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [smef_pkg::TAG_W-1:0]  sensor_tag,
  input  wire logic signed [smef_pkg::READ_W-1:0] reading,
  output logic                                   out_valid,
  output smef_pkg::win_beat_t                    out_beat,
  input  wire logic                              out_ready
);

  logic                               s1_valid;
  logic        [smef_pkg::TAG_W-1:0]  s1_tag;
  logic signed [smef_pkg::READ_W-1:0] s1_reading;
  logic                               s1_adv;
  logic                               accept;

  logic [smef_pkg::TAG_W-1:0]   diff;
  logic                         hit;
  logic [smef_pkg::SEL_W-1:0]   sel;
  logic [smef_pkg::POS_W-1:0]   pos;
  logic [smef_pkg::POS_W-1:0]   pos_next;
  smef_pkg::sample_t            sample;
  smef_pkg::window_t            new_win;
  logic                         ring_wr;

  smef_pkg::window_t [smef_pkg::SENSOR_COUNT-1:0]      ring;
  logic [smef_pkg::SENSOR_COUNT-1:0][smef_pkg::POS_W-1:0] pos_tab;

  assign s1_adv   = !out_valid || out_ready;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // sensor select; a tag below the base never wraps into the window
  assign diff = s1_tag - cfg.tag_base;
  assign hit  = (s1_tag >= cfg.tag_base) &&
                (diff < smef_pkg::TAG_W'(smef_pkg::SENSOR_COUNT));
  assign sel  = diff[smef_pkg::SEL_W-1:0];

  always_comb begin
    if (s1_reading == '0 || s1_reading[smef_pkg::READ_W-1]) begin
      sample = cfg.no_echo;
    end else if (s1_reading[smef_pkg::READ_W-2:smef_pkg::SAMPLE_W] != '0) begin
      sample = '1;
    end else begin
      sample = s1_reading[smef_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    pos = pos_tab[sel];
    if (pos > smef_pkg::POS_W'(smef_pkg::WINDOW - 1)) begin
      pos = '0;
    end
    pos_next = (pos == smef_pkg::POS_W'(smef_pkg::WINDOW - 1)) ? '0 : pos + 1'b1;
    new_win      = ring[sel];
    new_win[pos] = sample;
  end

  assign ring_wr = s1_valid && hit && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag     <= sensor_tag;
      s1_reading <= reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring    <= '0;
      pos_tab <= '0;
    end else if (ring_wr) begin
      ring[sel]    <= new_win;
      pos_tab[sel] <= pos_next;
    end
  end

  // drop beats whose tag misses the sonar window
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_wr) begin
      out_beat.sensor  <= sel;
      out_beat.samples <= new_win;
    end
  end

endmodule

`default_nettype wire

FILE: design/smef_median.sv
// Rank selection over one sensor's window, registered.
// Depends on smef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smef_median (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire smef_pkg::win_beat_t in_beat,
  output logic                     in_ready,
  output logic                     out_valid,
  output smef_pkg::med_beat_t      out_beat,
  input  wire logic                out_ready
);

  logic [smef_pkg::WINDOW-1:0][smef_pkg::CNT_W-1:0] rank_of;
  smef_pkg::sample_t                                 median;

  assign in_ready = !out_valid || out_ready;

  // rank of each entry = number of entries that sort ahead of it; ties by index
  always_comb begin
    for (int i = 0; i < smef_pkg::WINDOW; i++) begin
      rank_of[i] = '0;
      for (int j = 0; j < smef_pkg::WINDOW; j++) begin
        if (j != i) begin
          if ((in_beat.samples[j] < in_beat.samples[i]) ||
              ((in_beat.samples[j] == in_beat.samples[i]) && (j < i))) begin
            rank_of[i] = rank_of[i] + 1'b1;
          end
        end
      end
    end
    median = '0;
    for (int i = 0; i < smef_pkg::WINDOW; i++) begin
      if (rank_of[i] == smef_pkg::CNT_W'(smef_pkg::RANK)) begin
        median = in_beat.samples[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat.sensor <= in_beat.sensor;
      out_beat.median <= median;
    end
  end

endmodule

`default_nettype wire

FILE: design/smef_ema_stage.sv
// Per-sensor exponential average in Q8 and the result register.
// Depends on smef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smef_ema_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire smef_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  input  wire smef_pkg::med_beat_t            in_beat,
  output logic                                in_ready,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [smef_pkg::IDX_W-1:0]          sensor_index,
  output logic [smef_pkg::SAMPLE_W-1:0]       window_median,
  output logic [smef_pkg::SMOOTH_W-1:0]       smoothed_q8
);

  logic [smef_pkg::SENSOR_COUNT-1:0][smef_pkg::SMOOTH_W-1:0] store;

  logic [smef_pkg::ALPHA_W-1:0]  alpha_eff;
  logic [smef_pkg::SMOOTH_W-1:0] old_avg;
  logic signed [24:0]            delta;
  logic signed [9:0]             alpha_s;
  logic signed [34:0]            prod;
  logic signed [35:0]            sum;
  logic [smef_pkg::SMOOTH_W-1:0] new_avg;
  logic                          fire;

  assign in_ready = !out_valid || !out_stall;
  assign fire     = in_valid && in_ready;

  // weights above one act as one
  assign alpha_eff = cfg.alpha[smef_pkg::ALPHA_W-1] ? smef_pkg::ALPHA_ONE : cfg.alpha;
  assign alpha_s   = $signed({1'b0, alpha_eff});
  assign old_avg   = store[in_beat.sensor];

  // a*M + (256-a)*old == 256*old + a*(M-old), round half up
  assign delta   = $signed({1'b0, in_beat.median, 8'h00}) - $signed({1'b0, old_avg});
  assign prod    = alpha_s * delta;
  assign sum     = $signed({4'b0000, old_avg, 8'h00}) + 36'(prod) + 36'sd128;
  assign new_avg = sum[31:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
    end else if (fire) begin
      store[in_beat.sensor] <= new_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sensor_index  <= smef_pkg::IDX_W'(in_beat.sensor);
      window_median <= in_beat.median;
      smoothed_q8   <= new_avg;
    end
  end

endmodule

`default_nettype wire
